// ----- hdl/dnsare_pkg.sv -----
// Shared types and constants for the DNS answer record extractor.
// Depends on nothing; used by dns_answer_record_extractor and the testbench.
package dnsare_pkg;

	// Fixed field sizes and the name pointer mark of the DNS wire format
	localparam int unsigned HEADER_BYTES = 12;
	localparam int unsigned QFIXED_BYTES = 4;
	localparam int unsigned AFIXED_BYTES = 10;
	localparam logic [7:0]  PTR_MARK     = 8'hC0;

	// Configuration register indexes
	localparam logic CFG_MATCH_CLASS = 1'b0;
	localparam logic CFG_MATCH_TYPE  = 1'b1;

	// Result item kinds
	localparam logic KIND_DATA   = 1'b0;
	localparam logic KIND_STATUS = 1'b1;

	// Message status codes
	localparam logic [1:0] ST_NO_MATCH  = 2'd0;
	localparam logic [1:0] ST_MATCHED   = 2'd1;
	localparam logic [1:0] ST_MALFORMED = 2'd2;
	localparam logic [1:0] ST_TOO_LONG  = 2'd3;

	typedef struct packed {
		logic        kind;
		logic [7:0]  data;
		logic [11:0] offset;
		logic [15:0] length;
		logic        rec_end;
		logic [1:0]  status;
	} result_t;

endpackage

// ----- hdl/dns_answer_record_extractor.sv -----
// A message byte accepted on the request channel is registered in the input stage and parsed
// there; its results enter the result queue when that stage advances, and the queue head offers them.
// Throughput: one byte per cycle; the final byte of a message may yield two results, which
// drain one per cycle while out_ready is high from a four-entry queue; the input holds while
// more than two wait. Reset (arst_n low, asynchronous): parser, input stage and queue clear;
// both match registers return to 1.
//
// DNS answer record extractor top level. Uses dnsare_pkg (types and constants).
module dns_answer_record_extractor #(
	parameter int unsigned MAX_MESSAGE_BYTES = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	// message byte request channel
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  msg_byte,
	input  logic        msg_last,
	// result request channel
	output logic        out_valid,
	input  logic        out_ready,
	output logic        item_kind,
	output logic [7:0]  data_byte,
	output logic [11:0] message_offset,
	output logic [15:0] record_length,
	output logic        record_end,
	output logic [1:0]  status,
	// configuration write port
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data
);

	// Position counter must hold MAX_MESSAGE_BYTES itself and at least the 12 offset bits.
	localparam int unsigned POS_RAW = $clog2(MAX_MESSAGE_BYTES + 1);
	localparam int unsigned POS_W   = (POS_RAW > 12) ? POS_RAW : 12;
	localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_MESSAGE_BYTES);

	localparam int unsigned QDEPTH = 4;
	localparam int unsigned QPTR_W = $clog2(QDEPTH);
	localparam logic [QPTR_W:0] QROOM2 = (QPTR_W+1)'(QDEPTH - 2);

	typedef enum logic [2:0] {
		PH_HEADER,
		PH_NAME_LEN,
		PH_NAME_LABEL,
		PH_NAME_PTR,
		PH_QFIXED,
		PH_AFIXED,
		PH_ADATA,
		PH_DONE
	} phase_t;

	// ------------------------------------------------------------------
	// Configuration registers
	// ------------------------------------------------------------------
	logic [15:0] match_class_q, match_type_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_class_q <= 16'd1;
			match_type_q  <= 16'd1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				dnsare_pkg::CFG_MATCH_CLASS: match_class_q <= cfg_data;
				dnsare_pkg::CFG_MATCH_TYPE:  match_type_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Input stage: hold one request until the result queue has room for two
	// ------------------------------------------------------------------
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;
	logic       adv;
	logic [QPTR_W:0] cnt_q;

	assign adv      = valid_s1 && (cnt_q <= QROOM2);
	assign in_ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= msg_byte;
			last_s1 <= msg_last;
		end
	end

	// ------------------------------------------------------------------
	// Parser state
	// ------------------------------------------------------------------
	phase_t          phase_q, phase_n;
	logic [3:0]      fc_q, fc_n;
	logic [15:0]     qleft_q, qleft_n;
	logic [15:0]     aleft_q, aleft_n;
	logic [7:0]      label_q, label_n;
	logic [15:0]     rtype_q, rtype_n;
	logic [15:0]     rclass_q, rclass_n;
	logic [15:0]     dleft_q, dleft_n;
	logic [15:0]     rlen_q, rlen_n;
	logic            rmatch_q, rmatch_n;
	logic            anym_q, anym_n;
	logic            toolong_q, toolong_n;
	logic [POS_W-1:0] pos_q, pos_n;

	// results produced by the byte in the input stage
	logic                push_data, push_stat;
	dnsare_pkg::result_t res_data, res_stat;

	always_comb begin
		logic        too_long_now;
		logic [3:0]  fc_inc;
		logic [15:0] dec16;
		logic [7:0]  dec8;
		logic        match_now;
		logic        more_items;

		too_long_now = (pos_q >= POS_MAX);
		fc_inc       = fc_q + 4'd1;
		dec8         = label_q - 8'd1;
		dec16        = 16'd0;
		match_now    = 1'b0;
		more_items   = 1'b0;

		phase_n   = phase_q;
		fc_n      = fc_q;
		qleft_n   = qleft_q;
		aleft_n   = aleft_q;
		label_n   = label_q;
		rtype_n   = rtype_q;
		rclass_n  = rclass_q;
		dleft_n   = dleft_q;
		rlen_n    = rlen_q;
		rmatch_n  = rmatch_q;
		anym_n    = anym_q;
		toolong_n = toolong_q;
		pos_n     = pos_q;

		push_data = 1'b0;
		res_data  = '0;
		res_stat  = '0;

		if (too_long_now) begin
			// stop parsing past the size limit
			toolong_n = 1'b1;
			phase_n   = PH_DONE;
		end else begin
			pos_n = pos_q + POS_W'(1);
			unique case (phase_q)
				PH_HEADER: begin
					case (fc_q)
						4'd4: qleft_n = {byte_s1, 8'h00};
						4'd5: qleft_n = {qleft_q[15:8], byte_s1};
						4'd6: aleft_n = {byte_s1, 8'h00};
						4'd7: aleft_n = {aleft_q[15:8], byte_s1};
						default: ;
					endcase
					fc_n = fc_inc;
					if (fc_inc >= 4'(dnsare_pkg::HEADER_BYTES)) begin
						fc_n       = 4'd0;
						more_items = (qleft_n != 16'd0) || (aleft_n != 16'd0);
						phase_n    = more_items ? PH_NAME_LEN : PH_DONE;
					end
				end
				PH_NAME_LEN: begin
					if (byte_s1 == 8'd0) begin
						fc_n    = 4'd0;
						phase_n = (qleft_q != 16'd0) ? PH_QFIXED : PH_AFIXED;
					end else if ((byte_s1 & dnsare_pkg::PTR_MARK) == dnsare_pkg::PTR_MARK) begin
						phase_n = PH_NAME_PTR;
					end else begin
						label_n = byte_s1;
						phase_n = PH_NAME_LABEL;
					end
				end
				PH_NAME_LABEL: begin
					label_n = dec8;
					if (dec8 == 8'd0) begin
						phase_n = PH_NAME_LEN;
					end
				end
				PH_NAME_PTR: begin
					fc_n    = 4'd0;
					phase_n = (qleft_q != 16'd0) ? PH_QFIXED : PH_AFIXED;
				end
				PH_QFIXED: begin
					fc_n = fc_inc;
					if (fc_inc >= 4'(dnsare_pkg::QFIXED_BYTES)) begin
						fc_n       = 4'd0;
						qleft_n    = qleft_q - 16'd1;
						more_items = (qleft_n != 16'd0) || (aleft_q != 16'd0);
						phase_n    = more_items ? PH_NAME_LEN : PH_DONE;
					end
				end
				PH_AFIXED: begin
					case (fc_q)
						4'd0: rtype_n  = {byte_s1, 8'h00};
						4'd1: rtype_n  = {rtype_q[15:8], byte_s1};
						4'd2: rclass_n = {byte_s1, 8'h00};
						4'd3: rclass_n = {rclass_q[15:8], byte_s1};
						4'd8: dleft_n  = {byte_s1, 8'h00};
						4'd9: dleft_n  = {dleft_q[15:8], byte_s1};
						default: ;
					endcase
					fc_n = fc_inc;
					if (fc_inc >= 4'(dnsare_pkg::AFIXED_BYTES)) begin
						fc_n      = 4'd0;
						aleft_n   = aleft_q - 16'd1;
						match_now = (rtype_n == match_type_q) && (rclass_n == match_class_q);
						rmatch_n  = match_now;
						anym_n    = anym_q || match_now;
						rlen_n    = dleft_n;
						if (dleft_n == 16'd0) begin
							more_items = (qleft_q != 16'd0) || (aleft_n != 16'd0);
							phase_n    = more_items ? PH_NAME_LEN : PH_DONE;
						end else begin
							phase_n = PH_ADATA;
						end
					end
				end
				PH_ADATA: begin
					dec16   = dleft_q - 16'd1;
					dleft_n = dec16;
					if (rmatch_q) begin
						push_data        = 1'b1;
						res_data.kind    = dnsare_pkg::KIND_DATA;
						res_data.data    = byte_s1;
						res_data.offset  = pos_q[11:0];
						res_data.length  = rlen_q;
						res_data.rec_end = (dec16 == 16'd0);
						res_data.status  = dnsare_pkg::ST_NO_MATCH;
					end
					if (dec16 == 16'd0) begin
						more_items = (qleft_q != 16'd0) || (aleft_q != 16'd0);
						phase_n    = more_items ? PH_NAME_LEN : PH_DONE;
					end
				end
				PH_DONE: ;
				default: ;
			endcase
		end

		// end-of-message status ranks too long over malformed over match
		push_stat     = last_s1;
		res_stat.kind = dnsare_pkg::KIND_STATUS;
		if (toolong_n) begin
			res_stat.status = dnsare_pkg::ST_TOO_LONG;
		end else if (phase_n != PH_DONE) begin
			res_stat.status = dnsare_pkg::ST_MALFORMED;
		end else if (anym_n) begin
			res_stat.status = dnsare_pkg::ST_MATCHED;
		end else begin
			res_stat.status = dnsare_pkg::ST_NO_MATCH;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_HEADER;
			fc_q      <= '0;
			qleft_q   <= '0;
			aleft_q   <= '0;
			label_q   <= '0;
			rtype_q   <= '0;
			rclass_q  <= '0;
			dleft_q   <= '0;
			rlen_q    <= '0;
			rmatch_q  <= 1'b0;
			anym_q    <= 1'b0;
			toolong_q <= 1'b0;
			pos_q     <= '0;
		end else if (adv) begin
			if (last_s1) begin
				// drop all message state after the status item
				phase_q   <= PH_HEADER;
				fc_q      <= '0;
				qleft_q   <= '0;
				aleft_q   <= '0;
				label_q   <= '0;
				rtype_q   <= '0;
				rclass_q  <= '0;
				dleft_q   <= '0;
				rlen_q    <= '0;
				rmatch_q  <= 1'b0;
				anym_q    <= 1'b0;
				toolong_q <= 1'b0;
				pos_q     <= '0;
			end else begin
				phase_q   <= phase_n;
				fc_q      <= fc_n;
				qleft_q   <= qleft_n;
				aleft_q   <= aleft_n;
				label_q   <= label_n;
				rtype_q   <= rtype_n;
				rclass_q  <= rclass_n;
				dleft_q   <= dleft_n;
				rlen_q    <= rlen_n;
				rmatch_q  <= rmatch_n;
				anym_q    <= anym_n;
				toolong_q <= toolong_n;
				pos_q     <= pos_n;
			end
		end
	end

	// ------------------------------------------------------------------
	// Result queue: up to two pushes and one pop per cycle
	// ------------------------------------------------------------------
	dnsare_pkg::result_t q_mem [QDEPTH];
	logic [QPTR_W-1:0] wr_q, rd_q;
	logic       pop;
	logic [1:0] push_n;

	assign pop    = out_valid && out_ready;
	assign push_n = adv ? (2'(push_data) + 2'(push_stat)) : 2'd0;

	always_ff @(posedge clk) begin
		if (adv) begin
			if (push_data) begin
				q_mem[wr_q] <= res_data;
				if (push_stat) begin
					q_mem[wr_q + QPTR_W'(1)] <= res_stat;
				end
			end else if (push_stat) begin
				q_mem[wr_q] <= res_stat;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + QPTR_W'(push_n);
			if (pop) begin
				rd_q <= rd_q + QPTR_W'(1);
			end
			cnt_q <= cnt_q + (QPTR_W+1)'(push_n) - (QPTR_W+1)'(pop);
		end
	end

	dnsare_pkg::result_t head;
	assign head           = q_mem[rd_q];
	assign out_valid      = (cnt_q != '0);
	assign item_kind      = head.kind;
	assign data_byte      = head.data;
	assign message_offset = head.offset;
	assign record_length  = head.length;
	assign record_end     = head.rec_end;
	assign status         = head.status;

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= (QPTR_W+1)'(QDEPTH))
		else $error("result queue overflow");

	a_pos_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= POS_MAX)
		else $error("byte position ran past limit");

	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		adv && last_s1 |=> phase_q == PH_HEADER && pos_q == '0 && !anym_q)
		else $error("message state not cleared after final byte");

	a_status_pushed: assert property (@(posedge clk) disable iff (!arst_n)
		adv && last_s1 |=> cnt_q != '0)
		else $error("final byte produced no status result");

	a_label_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_NAME_LABEL |-> label_q != 8'd0)
		else $error("label phase with zero count");

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for dns_answer_record_extractor: streams DNS responses through the
// byte request channel and checks each result against a parser model that runs alongside.
// Depends on dnsare_pkg and the extractor RTL.
module testbench;

	localparam int MAX_MESSAGE_BYTES = 4096;
	localparam int CYCLE_LIMIT       = 600000;
	localparam int HOLDOFF_CYCLES    = 400;
	// a byte's results pass through the input stage and the result queue; leave margin for the queue
	localparam int DRAIN_CYCLES      = 6;
	localparam int RANDOM_PHASE_BYTES = 300;

	// Parser position inside the message, as the model tracks it
	typedef enum logic [2:0] {
		PS_HEADER,
		PS_NAME_LEN,
		PS_NAME_LABEL,
		PS_NAME_PTR,
		PS_QFIXED,
		PS_AFIXED,
		PS_ADATA,
		PS_DONE
	} parse_phase_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [7:0]  msg_byte;
	logic        msg_last;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic        item_kind;
	logic [7:0]  data_byte;
	logic [11:0] message_offset;
	logic [15:0] record_length;
	logic        record_end;
	logic [1:0]  status;
	logic        cfg_we;
	logic        cfg_index;
	logic [15:0] cfg_data;

	dns_answer_record_extractor #(
		.MAX_MESSAGE_BYTES(MAX_MESSAGE_BYTES)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.msg_byte(msg_byte),
		.msg_last(msg_last),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.item_kind(item_kind),
		.data_byte(data_byte),
		.message_offset(message_offset),
		.record_length(record_length),
		.record_end(record_end),
		.status(status),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// Parser model state and its copy of the match registers
	parse_phase_t ps_phase;
	logic [3:0]   ps_field_cnt;
	logic [15:0]  ps_questions;
	logic [15:0]  ps_answers;
	logic [7:0]   ps_label_left;
	logic [15:0]  ps_type;
	logic [15:0]  ps_class;
	logic [15:0]  ps_data_left;
	logic [15:0]  ps_rec_len;
	logic [12:0]  ps_pos;
	logic         ps_any_match;
	logic         ps_too_long;
	logic         ps_rec_match;
	logic [15:0]  match_class_reg;
	logic [15:0]  match_type_reg;

	// Results the block still owes, oldest first
	dnsare_pkg::result_t awaited_results[$];
	// Message under construction
	logic [7:0] msg_q[$];

	int send_idle_pct;
	int recv_idle_pct;
	bit hold_request;
	int hold_left;
	int cycle_count;
	int fail_count;
	int unsigned bytes_sent;
	int unsigned messages_sent;
	int unsigned data_results;
	int unsigned status_count[4];

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// ---------------------------------------------------------------- parser model

	function automatic void clear_parse();
		ps_phase      = PS_HEADER;
		ps_field_cnt  = '0;
		ps_questions  = '0;
		ps_answers    = '0;
		ps_label_left = '0;
		ps_type       = '0;
		ps_class      = '0;
		ps_data_left  = '0;
		ps_rec_len    = '0;
		ps_pos        = '0;
		ps_any_match  = 1'b0;
		ps_too_long   = 1'b0;
		ps_rec_match  = 1'b0;
	endfunction

	// After a header, question or answer: another name follows, or the message is complete
	function automatic void next_section();
		ps_phase = (ps_questions != 0 || ps_answers != 0) ? PS_NAME_LEN : PS_DONE;
	endfunction

	function automatic void end_of_name();
		ps_field_cnt = '0;
		ps_phase = (ps_questions != 0) ? PS_QFIXED : PS_AFIXED;
	endfunction

	// Advance the model by one accepted byte and queue the results it owes
	function automatic void parse_byte(input logic [7:0] b, input logic last);
		dnsare_pkg::result_t r;
		logic [11:0] offs;
		offs = ps_pos[11:0];
		if (ps_pos >= MAX_MESSAGE_BYTES) begin
			// past the size limit nothing is parsed any more
			ps_too_long = 1'b1;
			ps_phase = PS_DONE;
		end else begin
			ps_pos = ps_pos + 1'b1;
			case (ps_phase)
				PS_HEADER: begin
					if (ps_field_cnt == 4) ps_questions = {b, 8'h00};
					else if (ps_field_cnt == 5) ps_questions[7:0] = b;
					else if (ps_field_cnt == 6) ps_answers = {b, 8'h00};
					else if (ps_field_cnt == 7) ps_answers[7:0] = b;
					ps_field_cnt = ps_field_cnt + 1'b1;
					if (ps_field_cnt >= dnsare_pkg::HEADER_BYTES) begin
						ps_field_cnt = '0;
						next_section();
					end
				end
				PS_NAME_LEN: begin
					if (b == 8'h00) begin
						end_of_name();
					end else if ((b & dnsare_pkg::PTR_MARK) == dnsare_pkg::PTR_MARK) begin
						ps_phase = PS_NAME_PTR;
					end else begin
						// one top bit alone still counts as a plain length
						ps_label_left = b;
						ps_phase = PS_NAME_LABEL;
					end
				end
				PS_NAME_LABEL: begin
					ps_label_left = ps_label_left - 1'b1;
					if (ps_label_left == 0) ps_phase = PS_NAME_LEN;
				end
				PS_NAME_PTR: end_of_name();
				PS_QFIXED: begin
					ps_field_cnt = ps_field_cnt + 1'b1;
					if (ps_field_cnt >= dnsare_pkg::QFIXED_BYTES) begin
						ps_field_cnt = '0;
						ps_questions = ps_questions - 1'b1;
						next_section();
					end
				end
				PS_AFIXED: begin
					case (ps_field_cnt)
						4'd0: ps_type = {b, 8'h00};
						4'd1: ps_type[7:0] = b;
						4'd2: ps_class = {b, 8'h00};
						4'd3: ps_class[7:0] = b;
						4'd8: ps_data_left = {b, 8'h00};
						4'd9: ps_data_left[7:0] = b;
						default: ;
					endcase
					ps_field_cnt = ps_field_cnt + 1'b1;
					if (ps_field_cnt >= dnsare_pkg::AFIXED_BYTES) begin
						ps_field_cnt = '0;
						ps_answers = ps_answers - 1'b1;
						ps_rec_match = (ps_type == match_type_reg) &&
							(ps_class == match_class_reg);
						if (ps_rec_match) ps_any_match = 1'b1;
						ps_rec_len = ps_data_left;
						if (ps_data_left == 0) next_section();
						else ps_phase = PS_ADATA;
					end
				end
				PS_ADATA: begin
					ps_data_left = ps_data_left - 1'b1;
					if (ps_rec_match) begin
						r = '0;
						r.kind    = dnsare_pkg::KIND_DATA;
						r.data    = b;
						r.offset  = offs;
						r.length  = ps_rec_len;
						r.rec_end = (ps_data_left == 0);
						awaited_results.push_back(r);
					end
					if (ps_data_left == 0) next_section();
				end
				default: ;
			endcase
		end
		if (last) begin
			// the status follows any data item of the same byte
			r = '0;
			r.kind = dnsare_pkg::KIND_STATUS;
			if (ps_too_long) r.status = dnsare_pkg::ST_TOO_LONG;
			else if (ps_phase != PS_DONE) r.status = dnsare_pkg::ST_MALFORMED;
			else r.status = ps_any_match ? dnsare_pkg::ST_MATCHED : dnsare_pkg::ST_NO_MATCH;
			awaited_results.push_back(r);
			clear_parse();
		end
	endfunction

	// ---------------------------------------------------------------- message building

	function automatic logic [7:0] rand_byte();
		return 8'($urandom_range(0, 255));
	endfunction

	function automatic void put_header(input logic [15:0] qd, input logic [15:0] an);
		repeat (4) msg_q.push_back(rand_byte());
		msg_q.push_back(qd[15:8]);
		msg_q.push_back(qd[7:0]);
		msg_q.push_back(an[15:8]);
		msg_q.push_back(an[7:0]);
		repeat (4) msg_q.push_back(rand_byte());
	endfunction

	// style: 0 root, 1 pointer, 2 labels then root, 3 labels then pointer, <0 any
	function automatic void put_name(input int style);
		int r;
		int len;
		if (style < 0) style = $urandom_range(0, 3);
		if (style >= 2) begin
			repeat ($urandom_range(1, 3)) begin
				r = $urandom_range(0, 39);
				len = (r == 0) ? 8'h80 : (r < 3) ? 8'h40 + r : $urandom_range(1, 6);
				msg_q.push_back(8'(len));
				repeat (len) msg_q.push_back(rand_byte());
			end
		end
		if (style == 0 || style == 2) begin
			msg_q.push_back(8'h00);
		end else begin
			msg_q.push_back(dnsare_pkg::PTR_MARK | 8'($urandom_range(0, 63)));
			msg_q.push_back(rand_byte());
		end
	endfunction

	function automatic void put_question();
		put_name(-1);
		repeat (dnsare_pkg::QFIXED_BYTES) msg_q.push_back(rand_byte());
	endfunction

	// Fixed part of an answer (type, class, TTL, length) and its data
	function automatic void put_record(input logic [15:0] ty, input logic [15:0] cl,
		input int len);
		logic [15:0] len16;
		len16 = 16'(len);
		msg_q.push_back(ty[15:8]);
		msg_q.push_back(ty[7:0]);
		msg_q.push_back(cl[15:8]);
		msg_q.push_back(cl[7:0]);
		repeat (4) msg_q.push_back(rand_byte());
		msg_q.push_back(len16[15:8]);
		msg_q.push_back(len16[7:0]);
		repeat (len) msg_q.push_back(rand_byte());
	endfunction

	function automatic void put_answer(input logic [15:0] ty, input logic [15:0] cl,
		input int len, input int style);
		put_name(style);
		put_record(ty, cl, len);
	endfunction

	// Mostly well-formed responses; some cut short, a few pure noise
	function automatic void build_random_message();
		int kind;
		int qd;
		int an;
		int r;
		int cut;
		logic [15:0] ty;
		logic [15:0] cl;
		kind = $urandom_range(0, 99);
		if (kind < 8) begin
			repeat ($urandom_range(1, 24)) msg_q.push_back(rand_byte());
			return;
		end
		qd = $urandom_range(0, 2);
		an = $urandom_range(0, 3);
		put_header(16'(qd), 16'(an));
		repeat (qd) put_question();
		repeat (an) begin
			r = $urandom_range(0, 9);
			ty = (r < 7) ? match_type_reg : 16'($urandom_range(0, 65535));
			cl = (r < 6 || r == 7) ? match_class_reg : 16'($urandom_range(0, 65535));
			put_answer(ty, cl, ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 10), -1);
		end
		// authority or additional bytes that the parser skips
		if ($urandom_range(0, 3) == 0)
			repeat ($urandom_range(1, 6)) msg_q.push_back(rand_byte());
		if (kind < 22 && msg_q.size() > 1) begin
			cut = $urandom_range(1, msg_q.size() - 1);
			msg_q = msg_q[0:cut - 1];
		end
	endfunction

	// ---------------------------------------------------------------- drivers

	// Offer one byte; drop valid for random idle cycles first, then hold until taken
	task automatic send_byte(input logic [7:0] b, input logic last);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			@(negedge clk);
			in_valid <= 1'b0;
		end
		@(negedge clk);
		in_valid <= 1'b1;
		msg_byte <= b;
		msg_last <= last;
		do @(posedge clk); while (!in_ready);
		parse_byte(b, last);
		bytes_sent++;
	endtask

	task automatic send_message();
		foreach (msg_q[i]) send_byte(msg_q[i], i == msg_q.size() - 1);
		msg_q.delete();
		messages_sent++;
	endtask

	// Drop the request line and let every owed result drain out
	task automatic wait_drained();
		@(negedge clk);
		in_valid <= 1'b0;
		while (awaited_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_register(input logic idx, input logic [15:0] value);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == dnsare_pkg::CFG_MATCH_CLASS) match_class_reg = value;
		else match_type_reg = value;
	endtask

	task automatic set_match(input logic [15:0] cl, input logic [15:0] ty);
		write_register(dnsare_pkg::CFG_MATCH_CLASS, cl);
		write_register(dnsare_pkg::CFG_MATCH_TYPE, ty);
	endtask

	// Result side: random stalls, plus a long hold-off when a test asks for one
	always @(negedge clk) begin
		if (hold_request) begin
			hold_left = HOLDOFF_CYCLES;
			hold_request = 1'b0;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	// ---------------------------------------------------------------- checking

	function automatic void compare_field(input string what, input int unsigned want,
		input int unsigned got);
		if (want != got) begin
			fail_count++;
			$display("%0t: %s mismatch: expected %0h, actual %0h", $time, what, want, got);
		end
	endfunction

	// Compare each taken result with the oldest one owed
	always @(posedge clk) begin : check_results
		dnsare_pkg::result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (item_kind == dnsare_pkg::KIND_STATUS) status_count[status]++;
			else data_results++;
			if (awaited_results.size() == 0) begin
				fail_count++;
				$display("%0t: unexpected result: expected none, actual kind %0d status %0d",
					$time, item_kind, status);
			end else begin
				want = awaited_results.pop_front();
				compare_field("item_kind", want.kind, item_kind);
				compare_field("data_byte", want.data, data_byte);
				compare_field("message_offset", want.offset, message_offset);
				compare_field("record_length", want.length, record_length);
				compare_field("record_end", want.rec_end, record_end);
				compare_field("status", want.status, status);
			end
		end
	end

	// Watchdog: a stuck handshake ends the run here
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// ---------------------------------------------------------------- tests

	// Header extremes, short messages and several ways a message can end early
	task automatic test_header_and_truncation();
		int i;
		// all-ones header bytes apart from zero counts: empty but complete
		for (i = 0; i < dnsare_pkg::HEADER_BYTES; i++)
			msg_q.push_back((i >= 4 && i < 8) ? 8'h00 : 8'hFF);
		send_message();
		msg_q.push_back(8'hFF);
		send_message();
		put_header(16'd0, 16'd0);
		void'(msg_q.pop_back());
		send_message();
		// counts at their maximum, then cut off
		put_header(16'hFFFF, 16'hFFFF);
		repeat (3) msg_q.push_back(rand_byte());
		send_message();
		// a name whose terminating zero is the final byte
		put_header(16'd1, 16'd0);
		msg_q.push_back(8'd3);
		repeat (3) msg_q.push_back(rand_byte());
		msg_q.push_back(8'h00);
		send_message();
		// answer fixed bytes cut short
		put_header(16'd0, 16'd1);
		msg_q.push_back(8'h00);
		repeat (5) msg_q.push_back(rand_byte());
		send_message();
		// one answer short, one question short
		put_header(16'd0, 16'd2);
		put_answer(16'd7, 16'd7, 1, 0);
		send_message();
		put_header(16'd2, 16'd0);
		put_question();
		send_message();
	endtask

	// Matching and non-matching records under the reset match values and the extremes
	task automatic test_record_matching();
		// record data ends on the final byte: data and status land together
		put_header(16'd1, 16'd1);
		put_question();
		put_answer(16'd1, 16'd1, 3, 1);
		send_message();
		// a matching record with no data still counts as a match
		put_header(16'd0, 16'd1);
		put_answer(16'd1, 16'd1, 0, 0);
		send_message();
		// only one of type and class matches, then skipped trailing bytes
		put_header(16'd0, 16'd2);
		put_answer(16'd1, 16'd3, 2, 0);
		put_answer(16'd5, 16'd1, 2, 3);
		repeat (3) msg_q.push_back(rand_byte());
		send_message();
		put_header(16'd0, 16'd2);
		put_answer(16'd1, 16'd1, 4, 1);
		put_answer(16'd2, 16'd1, 4, 0);
		repeat (2) msg_q.push_back(rand_byte());
		send_message();
		// data running past the end: bytes already out stay out
		put_header(16'd0, 16'd1);
		put_answer(16'd1, 16'd1, 6, 0);
		msg_q = msg_q[0:msg_q.size() - 4];
		send_message();
		wait_drained();
		set_match(16'hFFFF, 16'hFFFF);
		put_header(16'd0, 16'd2);
		put_answer(16'hFFFF, 16'hFFFF, 2, 1);
		put_answer(16'd1, 16'd1, 2, 1);
		send_message();
		wait_drained();
		set_match(16'h0000, 16'h0000);
		put_header(16'd0, 16'd1);
		put_answer(16'h0000, 16'h0000, 1, 0);
		send_message();
		wait_drained();
		set_match(16'd1, 16'd1);
	endtask

	// Longest plain labels, lengths with a single top bit, pointers at both ends of range
	task automatic test_name_forms();
		put_header(16'd1, 16'd2);
		msg_q.push_back(8'h3F);
		repeat (63) msg_q.push_back(rand_byte());
		msg_q.push_back(8'h40);
		repeat (64) msg_q.push_back(rand_byte());
		msg_q.push_back(8'h80);
		repeat (128) msg_q.push_back(rand_byte());
		msg_q.push_back(8'h00);
		repeat (dnsare_pkg::QFIXED_BYTES) msg_q.push_back(rand_byte());
		msg_q.push_back(8'hFF);
		msg_q.push_back(rand_byte());
		put_record(16'd1, 16'd1, 2);
		msg_q.push_back(8'h01);
		msg_q.push_back(rand_byte());
		msg_q.push_back(dnsare_pkg::PTR_MARK);
		msg_q.push_back(8'h00);
		put_record(16'd1, 16'd1, 1);
		send_message();
	endtask

	// A record still open when the size limit passes: offsets reach 4095, the bytes at
	// and after the limit are not parsed, and too long outranks malformed
	task automatic test_message_length_limit();
		int fill;
		fill = MAX_MESSAGE_BYTES - dnsare_pkg::HEADER_BYTES - 1 - dnsare_pkg::AFIXED_BYTES;
		put_header(16'd0, 16'd1);
		msg_q.push_back(8'h00);
		put_record(16'd1, 16'd1, fill + 8);
		msg_q = msg_q[0:MAX_MESSAGE_BYTES + 1];
		send_message();
	endtask

	// Hold the result side off for a long stretch while requests keep coming
	task automatic test_backpressure();
		logic [15:0] cl;
		logic [15:0] ty;
		wait_drained();
		cl = 16'($urandom_range(0, 65535));
		ty = 16'($urandom_range(0, 65535));
		set_match(cl, ty);
		@(posedge clk);
		hold_request = 1'b1;
		put_header(16'd0, 16'd2);
		put_answer(ty, cl, 40, -1);
		put_answer(ty, cl, 30, -1);
		send_message();
		repeat (4) begin
			build_random_message();
			send_message();
		end
	endtask

	// Three stretches of random traffic, each with its own idle mix and match values
	task automatic test_random_traffic();
		int unsigned phase_start;
		for (int ph = 0; ph < 3; ph++) begin
			wait_drained();
			case (ph)
				0: begin
					send_idle_pct = 9;
					recv_idle_pct = 81;
					set_match(16'h0000, 16'h0000);
				end
				1: begin
					send_idle_pct = 81;
					recv_idle_pct = 9;
					set_match(16'hFFFF, 16'hFFFF);
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
					set_match(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
				end
			endcase
			phase_start = bytes_sent;
			while (bytes_sent - phase_start < RANDOM_PHASE_BYTES) begin
				build_random_message();
				send_message();
			end
		end
	endtask

	// ---------------------------------------------------------------- sequence

	initial begin
		arst_n        = 1'b0;
		in_valid      = 1'b0;
		msg_byte      = '0;
		msg_last      = 1'b0;
		cfg_we        = 1'b0;
		cfg_index     = dnsare_pkg::CFG_MATCH_CLASS;
		cfg_data      = '0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_request  = 1'b0;
		hold_left     = 0;
		cycle_count   = 0;
		fail_count    = 0;
		bytes_sent    = 0;
		messages_sent = 0;
		data_results  = 0;
		foreach (status_count[i]) status_count[i] = 0;
		// the block comes out of reset matching class 1, type 1
		match_class_reg = 16'd1;
		match_type_reg  = 16'd1;
		clear_parse();
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_header_and_truncation();
		test_record_matching();
		test_name_forms();
		test_message_length_limit();
		test_backpressure();
		test_random_traffic();
		wait_drained();

		$display("covered %0d messages / %0d bytes, %0d record data results", messages_sent,
			bytes_sent, data_results);
		$display("status results: none %0d, matched %0d, malformed %0d, too long %0d",
			status_count[dnsare_pkg::ST_NO_MATCH], status_count[dnsare_pkg::ST_MATCHED],
			status_count[dnsare_pkg::ST_MALFORMED], status_count[dnsare_pkg::ST_TOO_LONG]);
		if (fail_count == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule

// ----- files.f -----
hdl/dnsare_pkg.sv
hdl/dns_answer_record_extractor.sv
tb/testbench.sv
